// ===== hw/rtl/tsd_pkg.sv =====
`default_nettype none

package tsd_pkg;

   localparam int YearWidth   = 14;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int HourWidth   = 5;
   localparam int MinuteWidth = 6;
   localparam int SecondWidth = 6;
   localparam int StampWidth  = YearWidth + MonthWidth + DayWidth + HourWidth
                                + MinuteWidth + SecondWidth;

   localparam int ElapsedWidth  = 39;
   localparam int RspDataWidth  = ((ElapsedWidth + 7) / 8) * 8;
   localparam int ReqDataWidth  = ((2 * StampWidth + 7) / 8) * 8;

   // day number fits 24 bits signed, seconds since epoch 41 bits signed
   localparam int DayNumWidth  = 24;
   localparam int TimeWidth    = 41;
   localparam int TodWidth     = 17;
   localparam int NumStages    = 5;

   // x / 25 == (x * Recip25) >> Recip25Shift for x below 4096
   localparam int Recip25Width = 13;
   localparam logic [Recip25Width-1:0] Recip25 = 13'd5243;
   localparam int Recip25Shift = 17;

   localparam logic [8:0]  DaysPerYear   = 9'd365;
   localparam logic [11:0] SecsPerHour   = 12'd3600;
   localparam logic [5:0]  SecsPerMinute = 6'd60;
   localparam logic [17:0] SecsPerDay    = 18'd86400;
   // 1 january of year zero sits one leap year before day 1
   localparam logic signed [DayNumWidth-1:0] YearZeroBase = -24'sd366;

   typedef struct packed {
      logic [SecondWidth-1:0] second;
      logic [MinuteWidth-1:0] minute;
      logic [HourWidth-1:0]   hour;
      logic [DayWidth-1:0]    day;
      logic [MonthWidth-1:0]  month;
      logic [YearWidth-1:0]   year;
   } stamp_type;

   // days before the first of the month, months outside 1..12 count as january
   function automatic logic [8:0] days_before_month(input logic [MonthWidth-1:0] month,
                                                    input logic leap);
      logic [8:0] days;
      unique case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      if (leap && month >= 4'd3 && month <= 4'd12) begin
         days = days + 9'd1;
      end
      return days;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/timestamp_seconds_difference.sv =====
// timestamp_seconds_difference
// takes two gregorian timestamps in one transaction on the req_ channel and
// returns the absolute number of seconds between them on the rsp_ channel.
// dates count from 1 january of year 1 with the 4/100/400 leap rule; fields
// are not range checked, out-of-range values carry arithmetically.
// a request passes the stage registers in order on its way to rsp_tvalid.
// throughput: one transaction per cycle while the output is not stalled,
// set by a five stage pipeline (operand multiplies, day number sum, scale
// by 86400, time of day add, subtract and absolute value), no shared unit.
// each stage holds its own valid bit and advances when the stage after it
// is empty or moving, so a stall on rsp_tready backs up stage by stage and
// bubbles are squeezed out; req_tready stays high while stage one can load.
// reset clears all valid bits; payload registers are not reset.
`default_nettype none

module timestamp_seconds_difference
   import tsd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // year_a, month_a, day_a, hour_a, minute_a, second_a,
   // year_b, month_b, day_b, hour_b, minute_b, second_b
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // elapsed_seconds, one zero pad bit on top
   output logic [RspDataWidth-1:0]      rsp_tdata
);

   logic [NumStages-1:0] valid_ff, valid_in, stage_rdy;

   stamp_type stamp [2];

   // stage 1: operand products
   logic [22:0]                 base365_ff [2], base365_in [2];
   logic [24:0]                 p100_ff [2], p100_in [2];
   logic [22:0]                 p400_ff [2], p400_in [2];
   logic [24:0]                 py100_ff [2], py100_in [2];
   logic [22:0]                 py400_ff [2], py400_in [2];
   logic [11:0]                 q4_ff [2], q4_in [2];
   logic [TodWidth-1:0]         tod1_ff [2], tod1_in [2];
   logic [YearWidth-1:0]        year_ff [2];
   logic [MonthWidth-1:0]       month_ff [2];
   logic [DayWidth-1:0]         mday_ff [2];
   // stage 2: day number
   logic signed [DayNumWidth-1:0] day_ff [2], day_in [2];
   logic                          leap_ff [2], leap_in [2];
   logic                          yzero_ff [2];
   logic [TodWidth-1:0]           tod2_ff [2];
   // stage 3: day number in seconds
   logic signed [TimeWidth-1:0]   prod_ff [2], prod_in [2];
   logic [TodWidth-1:0]           tod3_ff [2];
   // stage 4: full time in seconds
   logic signed [TimeWidth-1:0]   time_ff [2], time_in [2];
   // stage 5: result
   logic [ElapsedWidth-1:0]       elapsed_ff, elapsed_in;

   logic signed [TimeWidth-1:0]   delta;

   assign stamp[0] = stamp_type'(req_tdata[StampWidth-1:0]);
   assign stamp[1] = stamp_type'(req_tdata[2*StampWidth-1:StampWidth]);

   // per-stage ready chain from the output back
   always_comb begin
      stage_rdy[NumStages-1] = !valid_ff[NumStages-1] || rsp_tready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in[0] = stage_rdy[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = stage_rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_tready = stage_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      logic [YearWidth-1:0] prior;
      logic [7:0]           y100, q100;
      logic [5:0]           y400, q400;
      logic [12:0]          y100x25;
      logic [10:0]          y400x25;
      logic                 y4z, y100z, y400z;
      logic [8:0]           off;
      logic signed [DayNumWidth-1:0] dsum;
      for (int i = 0; i < 2; i++) begin
         // stage 1
         prior = stamp[i].year - YearWidth'(1);
         base365_in[i] = 23'(prior * DaysPerYear);
         q4_in[i]      = prior[YearWidth-1:2];
         p100_in[i]    = 25'(prior[YearWidth-1:2] * Recip25);
         p400_in[i]    = 23'(prior[YearWidth-1:4] * Recip25);
         py100_in[i]   = 25'(stamp[i].year[YearWidth-1:2] * Recip25);
         py400_in[i]   = 23'(stamp[i].year[YearWidth-1:4] * Recip25);
         tod1_in[i]    = TodWidth'(stamp[i].hour * SecsPerHour)
                         + TodWidth'(stamp[i].minute * SecsPerMinute)
                         + TodWidth'(stamp[i].second);

         // stage 2: leap test and day number
         y100    = p100_ff[i][24:Recip25Shift];
         q100    = y100;
         y400    = p400_ff[i][22:Recip25Shift];
         q400    = y400;
         y100    = py100_ff[i][24:Recip25Shift];
         y400    = py400_ff[i][22:Recip25Shift];
         y100x25 = {1'b0, y100, 4'b0} + {2'b0, y100, 3'b0} + {5'b0, y100};
         y400x25 = {1'b0, y400, 4'b0} + {2'b0, y400, 3'b0} + {5'b0, y400};
         y4z     = (year_ff[i][1:0] == 2'd0);
         y100z   = y4z && ({1'b0, year_ff[i][YearWidth-1:2]} == y100x25);
         y400z   = (year_ff[i][3:0] == 4'd0)
                   && ({1'b0, year_ff[i][YearWidth-1:4]} == y400x25);
         leap_in[i] = y4z && (!y100z || y400z);
         off = days_before_month(month_ff[i], leap_in[i]);
         if (year_ff[i] == '0) begin
            dsum = YearZeroBase;
         end else begin
            dsum = $signed({1'b0, base365_ff[i]})
                   + $signed(DayNumWidth'(q4_ff[i]))
                   - $signed(DayNumWidth'(q100))
                   + $signed(DayNumWidth'(q400));
         end
         day_in[i] = dsum + $signed(DayNumWidth'(off)) + $signed(DayNumWidth'(mday_ff[i]));

         // stage 3
         prod_in[i] = TimeWidth'(day_ff[i] * $signed(SecsPerDay));

         // stage 4
         time_in[i] = prod_ff[i] + $signed(TimeWidth'(tod3_ff[i]));
      end

      // stage 5
      delta = time_ff[1] - time_ff[0];
      elapsed_in = delta[TimeWidth-1] ? ElapsedWidth'(-delta) : ElapsedWidth'(delta);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         if (stage_rdy[0]) begin
            base365_ff[i] <= base365_in[i];
            p100_ff[i]    <= p100_in[i];
            p400_ff[i]    <= p400_in[i];
            py100_ff[i]   <= py100_in[i];
            py400_ff[i]   <= py400_in[i];
            q4_ff[i]      <= q4_in[i];
            tod1_ff[i]    <= tod1_in[i];
            year_ff[i]    <= stamp[i].year;
            month_ff[i]   <= stamp[i].month;
            mday_ff[i]    <= stamp[i].day;
         end
         if (stage_rdy[1]) begin
            day_ff[i]   <= day_in[i];
            leap_ff[i]  <= leap_in[i];
            yzero_ff[i] <= (year_ff[i] == '0);
            tod2_ff[i]  <= tod1_ff[i];
         end
         if (stage_rdy[2]) begin
            prod_ff[i] <= prod_in[i];
            tod3_ff[i] <= tod2_ff[i];
         end
         if (stage_rdy[3]) begin
            time_ff[i] <= time_in[i];
         end
      end
      if (stage_rdy[4]) begin
         elapsed_ff <= elapsed_in;
      end
   end

   assign rsp_tvalid = valid_ff[NumStages-1];
   assign rsp_tdata  = RspDataWidth'(elapsed_ff);

   // stage 4 keeps its transaction while stalled
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !stage_rdy[3]) |=> valid_ff[3])
      else $error("stage 4 dropped a stalled transaction");

   // stage 1 loads only when its downstream can take what it held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !stage_rdy[1]) |-> !req_tready)
      else $error("stage 1 accepted over a blocked transaction");

   // year zero is a leap year and starts the lowest day number
   a_year_zero_leap: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[1] && yzero_ff[0]) |-> (leap_ff[0] && day_ff[0] >= YearZeroBase))
      else $error("year zero handling broken");

   // day numbers never fall below the year zero base
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (day_ff[1] >= YearZeroBase && day_ff[0] >= YearZeroBase))
      else $error("day number out of range");

endmodule

`default_nettype wire
